// File: design/ipv4tm_pkg.sv
// ----------------------------------------------------------------------------
// ipv4tm_pkg
// Types and constants shared by the IPv4 text token matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4tm_pkg;

   localparam int CSR_ADDR_WIDTH = 3;

   // register index, taken from paddr[2]
   localparam logic REG_PREFIX_MODE = 1'b0;

   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_NINE  = 8'h39;
   localparam logic [7:0]  CHAR_DOT   = 8'h2E;
   localparam logic [7:0]  CHAR_SLASH = 8'h2F;

   localparam logic [11:0] OCTET_MAX  = 12'd255;
   localparam logic [8:0]  LENGTH_MAX = 9'd32;
   localparam logic [1:0]  DOTS_MAX   = 2'd3;
   localparam logic [2:0]  OCTETS_ALL = 3'd4;

   typedef enum logic [2:0] {
      PH_START,
      PH_DIGIT,
      PH_DOT,
      PH_SLASH,
      PH_PLEN
   } phase_type;

   typedef enum logic [1:0] {
      VERDICT_FAIL,
      VERDICT_INCOMPLETE,
      VERDICT_FULL
   } verdict_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  octet_value;
      logic [1:0]  dot_count;
      logic [2:0]  octet_count;
      logic [5:0]  length_value;
      logic        failed;
   } token_type;

   localparam token_type TOKEN_CLEAR = '{
      phase:        PH_START,
      octet_value:  8'd0,
      dot_count:    2'd0,
      octet_count:  3'd0,
      length_value: 6'd0,
      failed:       1'b0
   };

endpackage

`default_nettype wire

// File: design/ipv4tm_csr.sv
// ----------------------------------------------------------------------------
// ipv4tm_csr
// APB register block holding the prefix mode setting.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4tm_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ipv4tm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]                          csr_pwdata,
   output logic [31:0]                               csr_prdata,
   output logic                                      csr_pready,
   output logic                                      prefix_mode
);

   logic prefix_mode_ff;
   logic prefix_mode_in;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      prefix_mode_in = prefix_mode_ff;
      if (wr_en && (csr_paddr[2] == ipv4tm_pkg::REG_PREFIX_MODE)) begin
         prefix_mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_mode_ff <= 1'b0;
      end else begin
         prefix_mode_ff <= prefix_mode_in;
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == ipv4tm_pkg::REG_PREFIX_MODE) begin
         csr_prdata = {31'd0, prefix_mode_ff};
      end
   end

   assign prefix_mode = prefix_mode_ff;

endmodule

`default_nettype wire

// File: design/ipv4tm_token.sv
// ----------------------------------------------------------------------------
// ipv4tm_token
// Token state and per-character update with verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4tm_token (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step_en,
   input  wire logic [7:0]      char_code,
   input  wire logic            token_end,
   input  wire logic            prefix_mode,
   output ipv4tm_pkg::verdict_type verdict,
   output ipv4tm_pkg::token_type   token_state
);

   ipv4tm_pkg::token_type tok_ff;
   ipv4tm_pkg::token_type tok_in;
   ipv4tm_pkg::token_type tok_next;

   logic        is_digit;
   logic [3:0]  digit;
   logic [11:0] octet_sum;
   logic [8:0]  length_sum;

   assign is_digit   = (char_code >= ipv4tm_pkg::CHAR_ZERO) &&
                       (char_code <= ipv4tm_pkg::CHAR_NINE);
   assign digit      = is_digit ? 4'(char_code - ipv4tm_pkg::CHAR_ZERO) : 4'd0;
   assign octet_sum  = ({4'd0, tok_ff.octet_value} << 3) +
                       ({4'd0, tok_ff.octet_value} << 1) + {8'd0, digit};
   assign length_sum = ({3'd0, tok_ff.length_value} << 3) +
                       ({3'd0, tok_ff.length_value} << 1) + {5'd0, digit};

   always_comb begin
      tok_next = tok_ff;
      if (!tok_ff.failed) begin
         unique case (tok_ff.phase) inside
            ipv4tm_pkg::PH_START, ipv4tm_pkg::PH_DOT: begin
               if (!is_digit) begin
                  tok_next.failed = 1'b1;
               end else begin
                  tok_next.octet_value = {4'd0, digit};
                  tok_next.octet_count = tok_ff.octet_count + 3'd1;
                  tok_next.phase       = ipv4tm_pkg::PH_DIGIT;
               end
            end
            ipv4tm_pkg::PH_DIGIT: begin
               if (char_code == ipv4tm_pkg::CHAR_DOT) begin
                  if (tok_ff.dot_count >= ipv4tm_pkg::DOTS_MAX) begin
                     tok_next.failed = 1'b1;
                  end else begin
                     tok_next.dot_count = tok_ff.dot_count + 2'd1;
                     tok_next.phase     = ipv4tm_pkg::PH_DOT;
                  end
               end else if (char_code == ipv4tm_pkg::CHAR_SLASH && prefix_mode) begin
                  tok_next.phase = ipv4tm_pkg::PH_SLASH;
               end else if (is_digit) begin
                  if (octet_sum > ipv4tm_pkg::OCTET_MAX) begin
                     tok_next.failed = 1'b1;
                  end else begin
                     tok_next.octet_value = octet_sum[7:0];
                  end
               end else begin
                  tok_next.failed = 1'b1;
               end
            end
            ipv4tm_pkg::PH_SLASH: begin
               if (!is_digit) begin
                  tok_next.failed = 1'b1;
               end else begin
                  tok_next.length_value = {2'd0, digit};
                  tok_next.phase        = ipv4tm_pkg::PH_PLEN;
               end
            end
            ipv4tm_pkg::PH_PLEN: begin
               if (!is_digit || (length_sum > ipv4tm_pkg::LENGTH_MAX)) begin
                  tok_next.failed = 1'b1;
               end else begin
                  tok_next.length_value = length_sum[5:0];
               end
            end
            default: begin
               tok_next.failed = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      verdict = ipv4tm_pkg::VERDICT_INCOMPLETE;
      if (tok_next.failed) begin
         verdict = ipv4tm_pkg::VERDICT_FAIL;
      end else if (tok_next.octet_count == ipv4tm_pkg::OCTETS_ALL) begin
         if ((!prefix_mode && tok_next.phase == ipv4tm_pkg::PH_DIGIT) ||
             (prefix_mode && tok_next.phase == ipv4tm_pkg::PH_PLEN)) begin
            verdict = ipv4tm_pkg::VERDICT_FULL;
         end
      end
   end

   always_comb begin
      tok_in = tok_ff;
      if (step_en) begin
         tok_in = token_end ? ipv4tm_pkg::TOKEN_CLEAR : tok_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= ipv4tm_pkg::TOKEN_CLEAR;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign token_state = tok_ff;

endmodule

`default_nettype wire

// File: design/ipv4tm_core_unused_guard.sv
// ----------------------------------------------------------------------------
// ipv4tm_skid
// Input holding register with valid flag and stall control.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4tm_skid (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       req_tlast,
   input  wire logic       advance,
   output logic            hold_valid,
   output logic [7:0]      hold_char,
   output logic            hold_last
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] char_ff;
   logic       last_ff;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_char  = char_ff;
   assign hold_last  = last_ff;

endmodule

`default_nettype wire

// File: design/ipv4_text_token_matcher_core.sv
// ----------------------------------------------------------------------------
// ipv4_text_token_matcher_core
// Dotted-decimal IPv4 address / prefix checker over a character stream.
// ----------------------------------------------------------------------------
// Takes one character per cycle while req_tready is high and returns one
// verdict per character (fail, incomplete, full) from the result register,
// with tlast copied through. Throughput is one transaction per cycle while
// rsp_tready holds; the limit is the token state update. An input register
// and a result register separate the two sides, so a stalled result stops
// the next character from being taken only once the input register is full.
// Write prefix_mode only while no transaction is in flight; a change inside a token is allowed.
`default_nettype none

module ipv4_text_token_matcher_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [7:0]                           req_tdata,   // [7:0] char_code
   input  wire logic                                 req_tlast,   // token_end
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [7:0]                                rsp_tdata,   // [1:0] verdict, rest 0
   output logic                                      rsp_tlast,   // final_flag
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ipv4tm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]                          csr_pwdata,
   output logic [31:0]                               csr_prdata,
   output logic                                      csr_pready
);

   logic                    prefix_mode;
   logic                    advance;
   logic                    hold_valid;
   logic [7:0]              hold_char;
   logic                    hold_last;
   ipv4tm_pkg::verdict_type verdict;
   ipv4tm_pkg::token_type   token_state;

   logic                    out_valid_ff;
   logic                    out_valid_in;
   ipv4tm_pkg::verdict_type out_verdict_ff;
   logic                    out_last_ff;

   ipv4tm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .prefix_mode (prefix_mode)
   );

   ipv4tm_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_char  (hold_char),
      .hold_last  (hold_last)
   );

   assign advance = hold_valid && (!out_valid_ff || rsp_tready);

   ipv4tm_token u_token (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .char_code   (hold_char),
      .token_end   (hold_last),
      .prefix_mode (prefix_mode),
      .verdict     (verdict),
      .token_state (token_state)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_verdict_ff <= verdict;
         out_last_ff    <= hold_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_verdict_ff};
   assign rsp_tlast  = out_last_ff;

   // token state is clear after the last character moves on
   assert property (@(posedge clock) disable iff (reset)
      (advance && hold_last) |=> (token_state == ipv4tm_pkg::TOKEN_CLEAR))
      else $error("token state not cleared after last character");

   // a sticky failure yields a fail verdict
   assert property (@(posedge clock) disable iff (reset)
      (advance && token_state.failed) |=>
         (out_verdict_ff == ipv4tm_pkg::VERDICT_FAIL))
      else $error("failed token produced non-fail verdict");

   // full verdict needs four octets begun
   assert property (@(posedge clock) disable iff (reset)
      (advance && !hold_last && verdict == ipv4tm_pkg::VERDICT_FULL) |=>
         (token_state.octet_count == ipv4tm_pkg::OCTETS_ALL))
      else $error("full verdict without four octets");

endmodule

`default_nettype wire

// File: dv/ipv4tm_verdict_checker.sv
// ----------------------------------------------------------------------------
// ipv4tm_verdict_checker
// Watches the character and verdict streams of the IPv4 token matcher.
// ----------------------------------------------------------------------------
// Tracks prefix_mode from the CSR writes it sees. Rebuilds the token state for
// every accepted character and queues the expected verdict and final flag.
// Each accepted result is checked in order against that queue. The top gets
// the mismatch count, the number of results still owed and a few counts for
// its summary.
`timescale 1ns / 100ps
`default_nettype none

module ipv4tm_verdict_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   input  wire logic                                  req_tready,
   input  wire logic [7:0]                            req_tdata,   // [7:0] char_code
   input  wire logic                                  req_tlast,   // token_end
   input  wire logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire logic [7:0]                            rsp_tdata,   // [1:0] verdict, rest 0
   input  wire logic                                  rsp_tlast,   // final_flag
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [ipv4tm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]                           csr_pwdata,
   input  wire logic                                  csr_pready,
   output int                                         mismatch_count,
   output int                                         outstanding,
   output int                                         results_checked,
   output int                                         tokens_checked,
   output int                                         full_count,
   output int                                         fail_count
);

   typedef struct packed {
      ipv4tm_pkg::verdict_type verdict;
      logic                    final_flag;
   } token_verdict_type;

   token_verdict_type     expected_verdicts[$];
   token_verdict_type     head;
   ipv4tm_pkg::token_type tok;
   logic                  prefix_mode_q;

   function automatic ipv4tm_pkg::verdict_type scan_char(input logic [7:0] c);
      logic is_digit;
      int   d;
      int   t;
      is_digit = (c >= ipv4tm_pkg::CHAR_ZERO) && (c <= ipv4tm_pkg::CHAR_NINE);
      d = is_digit ? int'(c - ipv4tm_pkg::CHAR_ZERO) : 0;
      if (!tok.failed) begin
         case (tok.phase) inside
            ipv4tm_pkg::PH_START, ipv4tm_pkg::PH_DOT: begin
               if (!is_digit) begin
                  tok.failed = 1'b1;
               end else begin
                  tok.octet_value = 8'(d);
                  tok.octet_count = tok.octet_count + 3'd1;
                  tok.phase = ipv4tm_pkg::PH_DIGIT;
               end
            end
            ipv4tm_pkg::PH_DIGIT: begin
               if (c == ipv4tm_pkg::CHAR_DOT) begin
                  if (tok.dot_count >= ipv4tm_pkg::DOTS_MAX) begin
                     tok.failed = 1'b1;
                  end else begin
                     tok.dot_count = tok.dot_count + 2'd1;
                     tok.phase = ipv4tm_pkg::PH_DOT;
                  end
               end else if (c == ipv4tm_pkg::CHAR_SLASH && prefix_mode_q) begin
                  tok.phase = ipv4tm_pkg::PH_SLASH;
               end else if (is_digit) begin
                  t = int'(tok.octet_value) * 10 + d;
                  if (t > int'(ipv4tm_pkg::OCTET_MAX)) tok.failed = 1'b1;
                  else tok.octet_value = 8'(t);
               end else begin
                  tok.failed = 1'b1;
               end
            end
            ipv4tm_pkg::PH_SLASH: begin
               if (!is_digit) begin
                  tok.failed = 1'b1;
               end else begin
                  tok.length_value = 6'(d);
                  tok.phase = ipv4tm_pkg::PH_PLEN;
               end
            end
            ipv4tm_pkg::PH_PLEN: begin
               if (!is_digit) begin
                  tok.failed = 1'b1;
               end else begin
                  t = int'(tok.length_value) * 10 + d;
                  if (t > int'(ipv4tm_pkg::LENGTH_MAX)) tok.failed = 1'b1;
                  else tok.length_value = 6'(t);
               end
            end
            default: tok.failed = 1'b1;
         endcase
      end
      if (tok.failed) return ipv4tm_pkg::VERDICT_FAIL;
      if (tok.octet_count == ipv4tm_pkg::OCTETS_ALL &&
          ((!prefix_mode_q && tok.phase == ipv4tm_pkg::PH_DIGIT) ||
           (prefix_mode_q && tok.phase == ipv4tm_pkg::PH_PLEN)))
         return ipv4tm_pkg::VERDICT_FULL;
      return ipv4tm_pkg::VERDICT_INCOMPLETE;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         tok = ipv4tm_pkg::TOKEN_CLEAR;
         prefix_mode_q = 1'b0;
         expected_verdicts.delete();
         mismatch_count = 0;
         results_checked = 0;
         tokens_checked = 0;
         full_count = 0;
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == ipv4tm_pkg::REG_PREFIX_MODE)
            prefix_mode_q = csr_pwdata[0];

         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               $error("verdict transaction with nothing expected: tdata=%0h tlast=%0b",
                      rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               head = expected_verdicts.pop_front();
               results_checked++;
               if (rsp_tdata[1:0] !== head.verdict) begin
                  $error("verdict: expected %0d, got %0d", head.verdict, rsp_tdata[1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[7:2] !== 6'd0) begin
                  $error("tdata padding: expected 0, got %0h", rsp_tdata[7:2]);
                  mismatch_count++;
               end
               if (rsp_tlast !== head.final_flag) begin
                  $error("final_flag: expected %0b, got %0b", head.final_flag, rsp_tlast);
                  mismatch_count++;
               end
               if (head.final_flag) tokens_checked++;
               if (head.verdict == ipv4tm_pkg::VERDICT_FULL) full_count++;
               if (head.verdict == ipv4tm_pkg::VERDICT_FAIL) fail_count++;
            end
         end

         if (req_tvalid && req_tready) begin
            head.verdict = scan_char(req_tdata);
            head.final_flag = req_tlast;
            expected_verdicts = {expected_verdicts, head};
            if (req_tlast) tok = ipv4tm_pkg::TOKEN_CLEAR;
         end
      end
      // registered so the top never sees a count that misses this edge's push
      outstanding <= expected_verdicts.size();
   end

endmodule

`default_nettype wire

// File: dv/ipv4_text_token_matcher_core_tb.sv
// ----------------------------------------------------------------------------
// ipv4_text_token_matcher_core_tb
// Stream-level test of the IPv4 text token matcher.
// ----------------------------------------------------------------------------
// Sends directed tokens (octet and prefix length limits, trailing dot, stray
// and high characters, slash handling, mode change inside a token), then
// random tokens, mostly well formed with random octets and lengths, the rest
// mutated or noise. Runs four idle/stall phases and switches prefix_mode
// between tokens with the pipe drained. The checker predicts every verdict.
`timescale 1ns / 100ps
`default_nettype none

module ipv4_text_token_matcher_core_tb;

   logic                                  clock       = 1'b0;
   logic                                  reset       = 1'b1;
   logic                                  req_tvalid  = 1'b0;
   logic                                  req_tready;
   logic [7:0]                            req_tdata   = 8'd0;   // [7:0] char_code
   logic                                  req_tlast   = 1'b0;   // token_end
   logic                                  rsp_tvalid;
   logic                                  rsp_tready  = 1'b0;
   logic [7:0]                            rsp_tdata;            // [1:0] verdict, rest 0
   logic                                  rsp_tlast;            // final_flag
   logic                                  csr_psel    = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite  = 1'b0;
   logic [ipv4tm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [31:0]                           csr_pwdata  = 32'd0;
   logic [31:0]                           csr_prdata;
   logic                                  csr_pready;

   int mismatch_count;
   int outstanding;
   int results_checked;
   int tokens_checked;
   int full_count;
   int fail_count;

   int         gap_pct    = 0;
   int         stall_pct  = 0;
   int         chars_sent = 0;
   int         mode_writes = 0;
   logic       mode_now   = 1'b0;
   logic [7:0] token_chars[$];

   ipv4_text_token_matcher_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ipv4tm_verdict_checker u_verdict_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .tokens_checked  (tokens_checked),
      .full_count      (full_count),
      .fail_count      (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #(5_000_000);
      $display("ipv4_text_token_matcher_core verification failed");
      $finish;
   end

   task automatic send_char(input logic [7:0] c, input logic last);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic add_char(input logic [7:0] c);
      token_chars = {token_chars, c};
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   task automatic send_token(input logic with_end);
      foreach (token_chars[i])
         send_char(token_chars[i], with_end && (i == token_chars.size() - 1));
      token_chars.delete();
   endtask

   task automatic send_text(input string s, input logic with_end);
      push_text(s);
      send_token(with_end);
   endtask

   // hold off until every verdict owed has come back, then let the pipe settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_prefix_mode(input logic m);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {ipv4tm_pkg::REG_PREFIX_MODE, 2'b00};
      csr_pwdata  <= {31'd0, m};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      mode_now = m;
      mode_writes++;
   endtask

   task automatic add_number(input int lo, input int hi);
      if ($urandom_range(7) == 0) push_text("0");
      push_text($sformatf("%0d", $urandom_range(hi, lo)));
   endtask

   task automatic build_token();
      int kind;
      int n_oct;
      kind = $urandom_range(19);
      if (kind < 2) begin
         repeat ($urandom_range(4, 1)) add_char(8'($urandom_range(255)));
      end else begin
         n_oct = (kind == 2) ? $urandom_range(3, 1) : ((kind == 3) ? 5 : 4);
         for (int i = 0; i < n_oct; i++) begin
            if (i != 0) push_text(".");
            case ($urandom_range(3))
               0: add_number(0, 9);
               1: add_number(10, 99);
               2: add_number(100, 255);
               default: add_number(250, 299);
            endcase
         end
         if (mode_now || kind == 4) begin
            push_text("/");
            if ($urandom_range(3) == 0) add_number(33, 99);
            else add_number(0, 32);
         end
         case (kind)
            5: repeat ($urandom_range(token_chars.size() - 1)) void'(token_chars.pop_back());
            6: token_chars[$urandom_range(token_chars.size() - 1)] = 8'($urandom_range(255));
            7: push_text(".");
            default: ;
         endcase
      end
   endtask

   initial begin
      int phase_end;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed tokens, address mode
      set_prefix_mode(1'b0);
      send_text("255.0.09.1", 1'b1);
      send_text("256.1", 1'b1);
      send_text("9.9.", 1'b1);
      send_text("1/", 1'b1);
      add_char(8'hFF);
      add_char(8'h00);
      send_token(1'b1);
      send_text("1.2.3.4", 1'b0);
      set_prefix_mode(1'b1);
      send_text("/0", 1'b1);
      // directed tokens, prefix mode
      send_text("1.2.3.4/32", 1'b1);
      send_text("1/3", 1'b1);
      send_text("1.2.3.4/33", 1'b1);
      send_text("1.2.3.4/", 1'b0);
      set_prefix_mode(1'b0);
      send_text("8", 1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 80; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 80; end
            default: begin gap_pct = 25; stall_pct = 25; end
         endcase
         set_prefix_mode(1'($urandom_range(1)));
         phase_end = chars_sent + 125;
         while (chars_sent < phase_end) begin
            if ($urandom_range(9) == 0) set_prefix_mode(!mode_now);
            build_token();
            send_token($urandom_range(15) != 0);
         end
      end

      stall_pct = 0;
      drain_results();
      repeat (4) @(posedge clock);

      $display("Summary: %0d characters sent, %0d verdicts checked over %0d tokens",
               chars_sent, results_checked, tokens_checked);
      $display("Summary: %0d full, %0d failed verdicts; prefix_mode written %0d times",
               full_count, fail_count, mode_writes);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("ipv4_text_token_matcher_core verification clean");
      end else begin
         $display("ipv4_text_token_matcher_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
